>>> rtl/core/best_fit_chunk_allocator_unit_defines.svh
// assertion macros shared by the chunk allocator rtl
// used by bfca_datapath; expects clk and rst_n in scope
`ifndef BEST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define BFCA_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define BFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bfca_pkg.sv
// types and codes for the best fit chunk allocator
// used by bfca_ctrl, bfca_datapath and the top level
`default_nettype none

package bfca_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOMEM  = 2'd1;
    localparam logic [1:0] STATUS_BADPTR = 2'd2;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] length;
        logic [16:0] spare;
        logic        free;
    } entry_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_BEST,
        RD_MATCH,
        RD_NEXT,
        RD_PREV,
        RD_UP,
        RD_DOWN,
        RD_SUM
    } rd_mode_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_NEW,
        WR_BEST,
        WR_MERGED
    } wr_mode_t;

    typedef enum logic [1:0] {
        TOT_HOLD,
        TOT_SET1,
        TOT_INC,
        TOT_DROP
    } tot_op_t;

    typedef struct packed {
        rd_mode_t rd_mode;
        wr_mode_t wr_mode;
        tot_op_t  tot_op;
        logic     capture;
        logic     latch_plan;
        logic     clear_sum;
        logic     load_result;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic found;
        logic split;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/bfca_ctrl.sv
// sequencer for the chunk allocator: scans, table shifts and summary pass
// depends on bfca_pkg; drives bfca_datapath through cmd_t
`default_nettype none

module bfca_ctrl
    import bfca_pkg::*;
#(
    parameter int MAX_CHUNKS = 64
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_wr_en,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  out_valid,
    input  wire                                  out_stall,
    input  sts_t                                 sts,
    input  wire  [$clog2(MAX_CHUNKS+1)-1:0]      total,
    input  wire  [$clog2(MAX_CHUNKS)-1:0]        hit_idx,
    input  wire  [$clog2(MAX_CHUNKS+1)-1:0]      shift_start,
    output cmd_t                                 cmd,
    output logic [$clog2(MAX_CHUNKS)-1:0]        rd_addr
);

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_WNEW,
        ST_WBEST,
        ST_RDN,
        ST_RDP,
        ST_RDWAIT,
        ST_MERGE,
        ST_SHIFT_DN,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   i_next;
    logic [CNT_W-1:0]   hit_ext;

    assign hit_ext  = CNT_W'(hit_idx);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        rd_addr    = '0;
        cmd        = '{rd_mode: RD_NONE, wr_mode: WR_NONE, tot_op: TOT_HOLD,
                       capture: 1'b0, latch_plan: 1'b0, clear_sum: 1'b0,
                       load_result: 1'b0};
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.wr_mode = WR_INIT;
                cmd.tot_op  = TOT_SET1;
                state_next  = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    i_next      = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (i_reg < total)
                begin
                    cmd.rd_mode = (sts.op == OP_FREE) ? RD_MATCH : RD_BEST;
                    rd_addr     = i_reg[IDX_W-1:0];
                    i_next      = i_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.latch_plan = 1'b1;
                priority if (!sts.found)
                begin
                    cmd.clear_sum = 1'b1;
                    i_next        = '0;
                    state_next    = ST_SUM;
                end
                else if (sts.op == OP_FREE)
                begin
                    state_next = ST_RDN;
                end
                else if (sts.split)
                begin
                    i_next     = total;
                    state_next = ST_SHIFT_UP;
                end
                else
                begin
                    state_next = ST_WBEST;
                end
            end
            ST_SHIFT_UP:
            begin
                if (i_reg > hit_ext + CNT_W'(1))
                begin
                    cmd.rd_mode = RD_UP;
                    rd_addr     = IDX_W'(i_reg - CNT_W'(1));
                    i_next      = i_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_WNEW;
                end
            end
            ST_WNEW:
            begin
                cmd.wr_mode = WR_NEW;
                cmd.tot_op  = TOT_INC;
                state_next  = ST_WBEST;
            end
            ST_WBEST:
            begin
                cmd.wr_mode   = WR_BEST;
                cmd.clear_sum = 1'b1;
                i_next        = '0;
                state_next    = ST_SUM;
            end
            ST_RDN:
            begin
                if (hit_ext + CNT_W'(1) < total)
                begin
                    cmd.rd_mode = RD_NEXT;
                    rd_addr     = hit_idx + IDX_W'(1);
                end
                state_next = ST_RDP;
            end
            ST_RDP:
            begin
                if (hit_idx != '0)
                begin
                    cmd.rd_mode = RD_PREV;
                    rd_addr     = hit_idx - IDX_W'(1);
                end
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.wr_mode = WR_MERGED;
                i_next      = shift_start;
                state_next  = ST_SHIFT_DN;
            end
            ST_SHIFT_DN:
            begin
                if (i_reg < total)
                begin
                    cmd.rd_mode = RD_DOWN;
                    rd_addr     = i_reg[IDX_W-1:0];
                    i_next      = i_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.tot_op    = TOT_DROP;
                    cmd.clear_sum = 1'b1;
                    i_next        = '0;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (i_reg < total)
                begin
                    cmd.rd_mode = RD_SUM;
                    rd_addr     = i_reg[IDX_W-1:0];
                    i_next      = i_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!(out_valid && out_stall))
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bfca_datapath.sv
// chunk table memory, scan evaluation, summary accumulators and result registers
// depends on bfca_pkg and best_fit_chunk_allocator_unit_defines.svh
`default_nettype none
`include "best_fit_chunk_allocator_unit_defines.svh"

module bfca_datapath
    import bfca_pkg::*;
#(
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int MEM_BYTES    = 65536
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [16:0]                      cfg_wr_data,
    input  wire                              operation,
    input  wire  [16:0]                      request_bytes,
    input  wire  [15:0]                      chunk_address,
    input  cmd_t                             cmd,
    input  wire  [$clog2(MAX_CHUNKS)-1:0]    rd_addr,
    output sts_t                             sts,
    output logic [$clog2(MAX_CHUNKS+1)-1:0]  total,
    output logic [$clog2(MAX_CHUNKS)-1:0]    hit_idx,
    output logic [$clog2(MAX_CHUNKS+1)-1:0]  shift_start,
    input  wire                              out_stall,
    output logic                             out_valid,
    output logic [1:0]                       status,
    output logic [15:0]                      data_address,
    output logic [16:0]                      granted_overhang,
    output logic [16:0]                      largest_free,
    output logic [16:0]                      largest_allocated,
    output logic [16:0]                      overhang_total,
    output logic [6:0]                       free_chunk_count,
    output logic [6:0]                       used_chunk_count
);

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int SEG_TOP_INT = (MEM_BYTES < 65536) ? MEM_BYTES : 65536;
    localparam logic [16:0] SEG_TOP = 17'(SEG_TOP_INT);
    localparam logic [16:0] SEG_MIN = 17'd64;
    localparam logic [16:0] HDR17   = 17'(HEADER_BYTES);
    localparam logic [15:0] HDR16   = 16'(HEADER_BYTES);
    localparam logic [18:0] HDR2_19 = 19'(2 * HEADER_BYTES);

    entry_t             mem [MAX_CHUNKS];

    logic [16:0]        seg_reg;
    logic [CNT_W-1:0]   total_reg;
    logic               op_reg;
    logic [16:0]        req_reg;
    logic [15:0]        addr_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [15:0]        hit_start_reg;
    logic [16:0]        hit_len_reg;
    logic               split_reg;
    logic               nxt_free_reg;
    logic [16:0]        nxt_len_reg;
    logic               prv_free_reg;
    logic [16:0]        prv_len_reg;
    logic [15:0]        prv_start_reg;
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    rd_mode_t           rd_mode_reg;
    logic [6:0]         nfree_reg;
    logic [6:0]         nused_reg;
    logic [16:0]        big_free_reg;
    logic [16:0]        big_used_reg;
    logic [16:0]        spare_sum_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [15:0]        data_address_reg;
    logic [16:0]        overhang_reg;
    logic [16:0]        largest_free_reg;
    logic [16:0]        largest_used_reg;
    logic [16:0]        overhang_total_reg;
    logic [6:0]         free_count_reg;
    logic [6:0]         used_count_reg;

    logic               split_now;
    logic [16:0]        merged_len;
    logic [1:0]         drop;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [16:0]        seg_clamped;

    assign split_now = ({2'b00, hit_len_reg} >= ({2'b00, req_reg} + HDR2_19))
                       && (total_reg < CNT_W'(MAX_CHUNKS));
    assign merged_len = hit_len_reg + (nxt_free_reg ? (HDR17 + nxt_len_reg) : 17'd0);
    assign drop = {1'b0, nxt_free_reg} + {1'b0, prv_free_reg};

    assign sts.op    = op_reg;
    assign sts.found = found_reg;
    assign sts.split = split_now;

    assign total       = total_reg;
    assign hit_idx     = hit_idx_reg;
    assign shift_start = CNT_W'(hit_idx_reg) + CNT_W'(1) + CNT_W'(nxt_free_reg);

    always_comb
    begin
        priority if (cfg_wr_data < SEG_MIN)
        begin
            seg_clamped = SEG_MIN;
        end
        else if (cfg_wr_data > SEG_TOP)
        begin
            seg_clamped = SEG_TOP;
        end
        else
        begin
            seg_clamped = cfg_wr_data;
        end
    end

    // table write port: sequencer writes first, otherwise pipelined moves
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = hit_idx_reg;
        wr_data = rd_data_reg;
        unique case (cmd.wr_mode)
            WR_INIT:
            begin
                wr_addr        = '0;
                wr_data.start  = HDR16;
                wr_data.length = (seg_reg > HDR17) ? (seg_reg - HDR17) : 17'd0;
                wr_data.spare  = '0;
                wr_data.free   = 1'b1;
            end
            WR_NEW:
            begin
                wr_addr        = hit_idx_reg + IDX_W'(1);
                wr_data.start  = hit_start_reg + req_reg[15:0] + HDR16;
                wr_data.length = hit_len_reg - req_reg - HDR17;
                wr_data.spare  = '0;
                wr_data.free   = 1'b1;
            end
            WR_BEST:
            begin
                wr_addr        = hit_idx_reg;
                wr_data.start  = hit_start_reg;
                wr_data.length = split_reg ? req_reg : hit_len_reg;
                wr_data.spare  = split_reg ? 17'd0 : (hit_len_reg - req_reg);
                wr_data.free   = 1'b0;
            end
            WR_MERGED:
            begin
                if (prv_free_reg)
                begin
                    wr_addr        = hit_idx_reg - IDX_W'(1);
                    wr_data.start  = prv_start_reg;
                    wr_data.length = prv_len_reg + HDR17 + merged_len;
                end
                else
                begin
                    wr_addr        = hit_idx_reg;
                    wr_data.start  = hit_start_reg;
                    wr_data.length = merged_len;
                end
                wr_data.spare = '0;
                wr_data.free  = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
                if (rd_mode_reg == RD_UP)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + IDX_W'(1);
                end
                else if (rd_mode_reg == RD_DOWN)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - IDX_W'(drop);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_TOP;
            total_reg     <= CNT_W'(1);
            rd_mode_reg   <= RD_NONE;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                seg_reg <= seg_clamped;
            end
            rd_mode_reg <= cmd.rd_mode;
            rd_idx_reg  <= rd_addr;

            unique case (cmd.tot_op)
                TOT_SET1: total_reg <= CNT_W'(1);
                TOT_INC:  total_reg <= total_reg + CNT_W'(1);
                TOT_DROP: total_reg <= total_reg - CNT_W'(drop);
                default:  total_reg <= total_reg;
            endcase

            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_mode_reg == RD_BEST)
            begin
                if (rd_data_reg.free && (rd_data_reg.length >= req_reg)
                    && (!found_reg || (rd_data_reg.length < hit_len_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end
            else if (rd_mode_reg == RD_MATCH)
            begin
                if (!rd_data_reg.free && (rd_data_reg.start == addr_reg) && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            req_reg      <= request_bytes;
            addr_reg     <= chunk_address;
            nxt_free_reg <= 1'b0;
            prv_free_reg <= 1'b0;
        end
        if (cmd.latch_plan)
        begin
            split_reg <= split_now;
        end

        unique case (rd_mode_reg)
            RD_BEST:
            begin
                if (rd_data_reg.free && (rd_data_reg.length >= req_reg)
                    && (!found_reg || (rd_data_reg.length < hit_len_reg)))
                begin
                    hit_idx_reg   <= rd_idx_reg;
                    hit_start_reg <= rd_data_reg.start;
                    hit_len_reg   <= rd_data_reg.length;
                end
            end
            RD_MATCH:
            begin
                if (!rd_data_reg.free && (rd_data_reg.start == addr_reg) && !found_reg)
                begin
                    hit_idx_reg   <= rd_idx_reg;
                    hit_start_reg <= rd_data_reg.start;
                    hit_len_reg   <= rd_data_reg.length;
                end
            end
            RD_NEXT:
            begin
                nxt_free_reg <= rd_data_reg.free;
                nxt_len_reg  <= rd_data_reg.length;
            end
            RD_PREV:
            begin
                prv_free_reg  <= rd_data_reg.free;
                prv_len_reg   <= rd_data_reg.length;
                prv_start_reg <= rd_data_reg.start;
            end
            RD_SUM:
            begin
                if (rd_data_reg.free)
                begin
                    nfree_reg <= nfree_reg + 7'd1;
                    if (rd_data_reg.length > big_free_reg)
                    begin
                        big_free_reg <= rd_data_reg.length;
                    end
                end
                else
                begin
                    nused_reg     <= nused_reg + 7'd1;
                    spare_sum_reg <= spare_sum_reg + rd_data_reg.spare;
                    if (rd_data_reg.length > big_used_reg)
                    begin
                        big_used_reg <= rd_data_reg.length;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.clear_sum)
        begin
            nfree_reg     <= '0;
            nused_reg     <= '0;
            big_free_reg  <= '0;
            big_used_reg  <= '0;
            spare_sum_reg <= '0;
        end

        if (cmd.load_result)
        begin
            if (!found_reg)
            begin
                status_reg <= (op_reg == OP_FREE) ? STATUS_BADPTR : STATUS_NOMEM;
            end
            else
            begin
                status_reg <= STATUS_OK;
            end
            data_address_reg <= (found_reg && (op_reg == OP_ALLOC)) ? hit_start_reg : 16'd0;
            overhang_reg     <= (found_reg && (op_reg == OP_ALLOC) && !split_reg)
                                ? (hit_len_reg - req_reg) : 17'd0;
            largest_free_reg   <= big_free_reg;
            largest_used_reg   <= big_used_reg;
            overhang_total_reg <= spare_sum_reg;
            free_count_reg     <= nfree_reg;
            used_count_reg     <= nused_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign data_address      = data_address_reg;
    assign granted_overhang  = overhang_reg;
    assign largest_free      = largest_free_reg;
    assign largest_allocated = largest_used_reg;
    assign overhang_total    = overhang_total_reg;
    assign free_chunk_count  = free_count_reg;
    assign used_chunk_count  = used_count_reg;

    `BFCA_ASSERT_NOW(a_total_range, (total_reg != '0) && (total_reg <= CNT_W'(MAX_CHUNKS)), "chunk total out of range")
    `BFCA_ASSERT_NOW(a_split_room, (cmd.tot_op != TOT_INC) || (total_reg < CNT_W'(MAX_CHUNKS)), "split with full table")
    `BFCA_ASSERT_NEXT(a_count_match, cmd.load_result, (MAX_CHUNKS > 127) || ((8'(free_count_reg) + 8'(used_count_reg)) == 8'(total_reg)), "chunk counts disagree with table total")

endmodule

`default_nettype wire

>>> rtl/core/best_fit_chunk_allocator_unit.sv
// allocate scans all T table entries, shifts the entries above the chosen entry B up on a
// split, writes and sums the table; free scans, reads the neighbours of the freed entry K,
// merges, shifts the rest down and sums; one transaction in flight, the next is accepted in
// the cycle after the result loads; the result register lets the next transaction enter
// while a result waits; reset and every segment size write rebuild the table as one free chunk
`default_nettype none

module best_fit_chunk_allocator_unit
    import bfca_pkg::*;
#(
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int MEM_BYTES    = 65536
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [16:0] cfg_wr_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         operation,
    input  wire  [16:0] request_bytes,
    input  wire  [15:0] chunk_address,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic [15:0] data_address,
    output logic [16:0] granted_overhang,
    output logic [16:0] largest_free,
    output logic [16:0] largest_allocated,
    output logic [16:0] overhang_total,
    output logic [6:0]  free_chunk_count,
    output logic [6:0]  used_chunk_count
);

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    cmd_t               cmd;
    sts_t               sts;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   total;
    logic [IDX_W-1:0]   hit_idx;
    logic [CNT_W-1:0]   shift_start;

    bfca_ctrl #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sts         (sts),
        .total       (total),
        .hit_idx     (hit_idx),
        .shift_start (shift_start),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    bfca_datapath #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .HEADER_BYTES (HEADER_BYTES),
        .MEM_BYTES    (MEM_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .operation         (operation),
        .request_bytes     (request_bytes),
        .chunk_address     (chunk_address),
        .cmd               (cmd),
        .rd_addr           (rd_addr),
        .sts               (sts),
        .total             (total),
        .hit_idx           (hit_idx),
        .shift_start       (shift_start),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .status            (status),
        .data_address      (data_address),
        .granted_overhang  (granted_overhang),
        .largest_free      (largest_free),
        .largest_allocated (largest_allocated),
        .overhang_total    (overhang_total),
        .free_chunk_count  (free_chunk_count),
        .used_chunk_count  (used_chunk_count)
    );

endmodule

`default_nettype wire

>>> verif/tb_best_fit_chunk_allocator_unit.sv
// testbench for the best fit chunk allocator: drives allocate and free requests,
// predicts every result with a scoreboard that keeps its own chunk table and compares it
// depends on bfca_pkg and best_fit_chunk_allocator_unit
`timescale 1ns / 100ps
`default_nettype none

module tb_best_fit_chunk_allocator_unit;
    import bfca_pkg::*;

    localparam int CHUNK_LIMIT = 64;
    localparam int HDR = 16;
    localparam int SEG_TOP = 65536;
    localparam int SEG_BOTTOM = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_address;
        logic [16:0] granted_overhang;
        logic [16:0] largest_free;
        logic [16:0] largest_allocated;
        logic [16:0] overhang_total;
        logic [6:0]  free_chunk_count;
        logic [6:0]  used_chunk_count;
    } alloc_result_t;

    class chunk_table_scoreboard;
        int unsigned seg_size;
        int unsigned chunk_start[CHUNK_LIMIT];
        int unsigned chunk_len[CHUNK_LIMIT];
        int unsigned chunk_spare[CHUNK_LIMIT];
        bit          chunk_free[CHUNK_LIMIT];
        int unsigned chunk_count;
        alloc_result_t pending[$];
        int errors;
        int checked;

        function void rebuild(int unsigned value);
            if (value < SEG_BOTTOM) seg_size = SEG_BOTTOM;
            else if (value > SEG_TOP) seg_size = SEG_TOP;
            else seg_size = value;
            for (int i = 0; i < CHUNK_LIMIT; i++)
            begin
                chunk_start[i] = 0;
                chunk_len[i] = 0;
                chunk_spare[i] = 0;
                chunk_free[i] = 0;
            end
            chunk_start[0] = HDR;
            chunk_len[0] = seg_size - HDR;
            chunk_free[0] = 1;
            chunk_count = 1;
        endfunction

        function void drop_chunk(int unsigned k);
            for (int unsigned i = k; i + 1 < chunk_count; i++)
            begin
                chunk_start[i] = chunk_start[i + 1];
                chunk_len[i] = chunk_len[i + 1];
                chunk_spare[i] = chunk_spare[i + 1];
                chunk_free[i] = chunk_free[i + 1];
            end
            chunk_count--;
        endfunction

        // allocated data offsets, used to aim free requests at real chunks
        function int unsigned pick_used(output bit ok);
            int unsigned idx[$];
            for (int unsigned i = 0; i < chunk_count; i++)
                if (!chunk_free[i]) idx.push_back(i);
            ok = idx.size() > 0;
            if (!ok) return 0;
            return chunk_start[idx[$urandom_range(idx.size() - 1)]];
        endfunction

        function void note_request(logic op, logic [16:0] req, logic [15:0] addr);
            alloc_result_t r;
            int unsigned best, len, k, big_free, big_used, spare_sum, nfree, nused;
            bit found;
            r = '0;
            found = 0;
            best = 0;
            k = 0;
            if (op == OP_ALLOC)
            begin
                for (int unsigned i = 0; i < chunk_count; i++)
                    if (chunk_free[i] && chunk_len[i] >= req &&
                        (!found || chunk_len[i] < chunk_len[best]))
                    begin
                        best = i;
                        found = 1;
                    end
                if (!found) r.status = STATUS_NOMEM;
                else
                begin
                    len = chunk_len[best];
                    if (len >= req + 2 * HDR && chunk_count < CHUNK_LIMIT)
                    begin
                        for (int unsigned i = chunk_count; i > best + 1; i--)
                        begin
                            chunk_start[i] = chunk_start[i - 1];
                            chunk_len[i] = chunk_len[i - 1];
                            chunk_spare[i] = chunk_spare[i - 1];
                            chunk_free[i] = chunk_free[i - 1];
                        end
                        chunk_start[best + 1] = chunk_start[best] + req + HDR;
                        chunk_len[best + 1] = len - req - HDR;
                        chunk_spare[best + 1] = 0;
                        chunk_free[best + 1] = 1;
                        chunk_count++;
                        chunk_len[best] = req;
                        chunk_spare[best] = 0;
                    end
                    else chunk_spare[best] = len - req;
                    chunk_free[best] = 0;
                    r.status = STATUS_OK;
                    r.data_address = 16'(chunk_start[best]);
                    r.granted_overhang = 17'(chunk_spare[best]);
                end
            end
            else
            begin
                for (int unsigned i = 0; i < chunk_count; i++)
                    if (!found && !chunk_free[i] && chunk_start[i] == addr)
                    begin
                        k = i;
                        found = 1;
                    end
                if (!found) r.status = STATUS_BADPTR;
                else
                begin
                    r.status = STATUS_OK;
                    chunk_free[k] = 1;
                    chunk_spare[k] = 0;
                    if (k + 1 < chunk_count && chunk_free[k + 1])
                    begin
                        chunk_len[k] += HDR + chunk_len[k + 1];
                        drop_chunk(k + 1);
                    end
                    if (k > 0 && chunk_free[k - 1])
                    begin
                        chunk_len[k - 1] += HDR + chunk_len[k];
                        drop_chunk(k);
                    end
                end
            end
            big_free = 0;
            big_used = 0;
            spare_sum = 0;
            nfree = 0;
            nused = 0;
            for (int unsigned i = 0; i < chunk_count; i++)
                if (chunk_free[i])
                begin
                    nfree++;
                    if (chunk_len[i] > big_free) big_free = chunk_len[i];
                end
                else
                begin
                    nused++;
                    if (chunk_len[i] > big_used) big_used = chunk_len[i];
                    spare_sum += chunk_spare[i];
                end
            r.largest_free = 17'(big_free);
            r.largest_allocated = 17'(big_used);
            r.overhang_total = 17'(spare_sum);
            r.free_chunk_count = 7'(nfree);
            r.used_chunk_count = 7'(nused);
            pending.push_back(r);
        endfunction

        function void check_result(alloc_result_t act);
            alloc_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, act);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (exp.status != act.status)
                $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
            if (exp.data_address != act.data_address)
                $display("%0t: data_address expected %0d actual %0d", $time,
                         exp.data_address, act.data_address);
            if (exp.granted_overhang != act.granted_overhang)
                $display("%0t: granted_overhang expected %0d actual %0d", $time,
                         exp.granted_overhang, act.granted_overhang);
            if (exp.largest_free != act.largest_free)
                $display("%0t: largest_free expected %0d actual %0d", $time,
                         exp.largest_free, act.largest_free);
            if (exp.largest_allocated != act.largest_allocated)
                $display("%0t: largest_allocated expected %0d actual %0d", $time,
                         exp.largest_allocated, act.largest_allocated);
            if (exp.overhang_total != act.overhang_total)
                $display("%0t: overhang_total expected %0d actual %0d", $time,
                         exp.overhang_total, act.overhang_total);
            if (exp.free_chunk_count != act.free_chunk_count)
                $display("%0t: free_chunk_count expected %0d actual %0d", $time,
                         exp.free_chunk_count, act.free_chunk_count);
            if (exp.used_chunk_count != act.used_chunk_count)
                $display("%0t: used_chunk_count expected %0d actual %0d", $time,
                         exp.used_chunk_count, act.used_chunk_count);
            if (exp != act) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [16:0] request_bytes;
    logic [15:0] chunk_address;
    logic        out_valid;
    logic        out_stall;
    alloc_result_t result;

    chunk_table_scoreboard board;
    bit no_idle;
    int sent;

    best_fit_chunk_allocator_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .request_bytes     (request_bytes),
        .chunk_address     (chunk_address),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (result.status),
        .data_address      (result.data_address),
        .granted_overhang  (result.granted_overhang),
        .largest_free      (result.largest_free),
        .largest_allocated (result.largest_allocated),
        .overhang_total    (result.overhang_total),
        .free_chunk_count  (result.free_chunk_count),
        .used_chunk_count  (result.used_chunk_count)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall, check at each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) board.check_result(result);
            out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 27);
        end
    end

    task automatic send_request(logic op, logic [16:0] req, logic [15:0] addr);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        request_bytes <= req;
        chunk_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(op, req, addr);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (3 * CHUNK_LIMIT + 20) @(posedge clk);
    endtask

    task automatic write_segment(logic [16:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.rebuild(value);
        @(posedge clk);
    endtask

    task automatic free_some();
        bit ok;
        int unsigned a;
        a = board.pick_used(ok);
        if (ok) send_request(OP_FREE, 17'(0), a[15:0]);
        else send_request(OP_FREE, 17'(0), 16'($urandom));
    endtask

    task automatic random_phase(int count, int unsigned max_req);
        int unsigned pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_request(OP_ALLOC, 17'($urandom_range(max_req)), 16'($urandom));
            else if (pick < 88) free_some();
            else if (pick < 94)
                send_request(OP_FREE, 17'($urandom), 16'($urandom));
            else
                send_request(OP_ALLOC, 17'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        board = new();
        board.rebuild(SEG_TOP);
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        in_valid = 0;
        operation = OP_ALLOC;
        request_bytes = '0;
        chunk_address = '0;
        out_stall = 0;
        no_idle = 0;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, exact fit, split, overhang, bad pointer, merges
        send_request(OP_ALLOC, 17'd65536, 16'hffff);
        send_request(OP_ALLOC, 17'd65520, 16'h0);
        send_request(OP_FREE, 17'h1ffff, 16'd16);
        send_request(OP_FREE, 17'd0, 16'd16);
        send_request(OP_ALLOC, 17'd0, 16'd0);
        send_request(OP_ALLOC, 17'd100, 16'd0);
        send_request(OP_ALLOC, 17'd200, 16'd0);
        send_request(OP_FREE, 17'd0, 16'd32);
        send_request(OP_FREE, 17'd0, 16'hffff);
        send_request(OP_FREE, 17'd0, 16'd16);
        send_request(OP_FREE, 17'd0, 16'd148);
        send_request(OP_ALLOC, 17'h1ffff, 16'd0);
        write_segment(17'd64);
        send_request(OP_ALLOC, 17'd10, 16'd0);
        send_request(OP_ALLOC, 17'd48, 16'd0);
        send_request(OP_FREE, 17'd0, 16'd16);
        send_request(OP_ALLOC, 17'd48, 16'd0);
        write_segment(17'd0);
        send_request(OP_ALLOC, 17'd18, 16'd0);
        write_segment(17'h1ffff);
        // fill the table to its limit, then force overhang instead of splits
        for (int n = 0; n < CHUNK_LIMIT + 4; n++)
            send_request(OP_ALLOC, 17'($urandom_range(1, 40)), 16'($urandom));
        random_phase(60, 64);
        drain();

        random_phase(200, 2000);
        no_idle = 1;
        random_phase(100, 600);
        no_idle = 0;
        write_segment(17'd300);
        random_phase(150, 80);
        write_segment(17'($urandom_range(64, 65536)));
        random_phase(150, 4000);
        write_segment(17'd65536);
        random_phase(150, 70000);
        drain();

        $display("sent %0d requests, checked %0d results over several segment sizes",
                 sent, board.checked);
        $display("covered table full, overhang, bad pointers, merges and out of memory");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/bfca_pkg.sv
rtl/core/bfca_ctrl.sv
rtl/core/bfca_datapath.sv
rtl/core/best_fit_chunk_allocator_unit.sv
verif/tb_best_fit_chunk_allocator_unit.sv
